// ----- hdl/sha1bs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Shared types, constants and control structures of the hasher.
// ----------------------------------------------------------------------------
package sha1bs_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [4:0] chain_t;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [6:0] LAST_ROUND = 7'd79;

	localparam chain_t CHAIN_IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam word_t K0 = 32'h5a827999;
	localparam word_t K1 = 32'h6ed9eba1;
	localparam word_t K2 = 32'h8f1bbcdc;
	localparam word_t K3 = 32'hca62c1d6;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PAD   = 5'b00010,
		S_ROUND = 5'b00100,
		S_FINAL = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	typedef struct packed {
		logic       push;
		logic [7:0] byte_val;
		logic       load;
		logic       step;
		logic [6:0] round;
	} core_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/sha1bs_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Holds the 64-byte block window and the working variables, and runs one
// compression round per cycle with a rolling 16-word message schedule.
// ----------------------------------------------------------------------------
module sha1bs_core (
	input  wire                        clk,
	input  wire sha1bs_pkg::core_ctl_t ctl,
	input  wire sha1bs_pkg::chain_t    chain,
	output sha1bs_pkg::chain_t         work
);
	import sha1bs_pkg::*;

	logic [511:0] win_q;
	chain_t       work_q;
	word_t        w0, w2, w8, w13, wmix, wnew, wt, f, k, sum;
	word_t        a, b, c, d, e;

	assign a = work_q[0];
	assign b = work_q[1];
	assign c = work_q[2];
	assign d = work_q[3];
	assign e = work_q[4];

	assign w0 = win_q[511:480];
	assign w2 = win_q[447:416];
	assign w8 = win_q[255:224];
	assign w13 = win_q[95:64];
	assign wmix = w13 ^ w8 ^ w2 ^ w0;
	assign wnew = {wmix[30:0], wmix[31]};
	assign wt = (ctl.round < 7'd16) ? w0 : wnew;

	always_comb begin
		if (ctl.round < 7'd20) begin
			f = d ^ (b & (c ^ d));
			k = K0;
		end else if (ctl.round < 7'd40) begin
			f = b ^ c ^ d;
			k = K1;
		end else if (ctl.round < 7'd60) begin
			f = (b & c) | (d & (b | c));
			k = K2;
		end else begin
			f = b ^ c ^ d;
			k = K3;
		end
	end

	assign sum = {a[26:0], a[31:27]} + f + e + wt + k;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			win_q <= {win_q[503:0], ctl.byte_val};
		end else if (ctl.step) begin
			win_q <= {win_q[479:0], wt};
		end
		if (ctl.load) begin
			work_q <= chain;
		end else if (ctl.step) begin
			work_q[0] <= sum;
			work_q[1] <= a;
			work_q[2] <= {b[1:0], b[31:2]};
			work_q[3] <= c;
			work_q[4] <= d;
		end
	end

	assign work = work_q;

endmodule
`default_nettype wire

// ----- hdl/sha1_byte_stream_hasher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Each input transfer either appends one message byte (kind 0) or finishes
// the message (kind 1). A finish pads the message, compresses the last one or
// two blocks and presents the 160-bit digest as five words on the output.
// Both channels use valid and stall; stall is high whenever the sequencer is
// busy. The byte that fills the block starts 80 rounds of the shared round
// unit, one round per cycle, after which the result is folded into the chain
// words. A finish with f bytes buffered pads within one block when f is at
// most 55, and uses two blocks otherwise, since the padding then needs a
// second block. Padding bytes enter the block one per cycle through the same
// byte path. The digest is held in an output register until its transfer
// completes; data bytes are still taken meanwhile, and a later finish waits
// for it. After a digest is emitted, the chain words and counters return to
// their initial values. Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                kind,
	input  wire  [7:0]         data_byte,
	output logic               out_valid,
	input  wire                out_stall,
	output sha1bs_pkg::word_t  digest_h0,
	output sha1bs_pkg::word_t  digest_h1,
	output sha1bs_pkg::word_t  digest_h2,
	output sha1bs_pkg::word_t  digest_h3,
	output sha1bs_pkg::word_t  digest_h4
);
	import sha1bs_pkg::*;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [6:0]  round_q;
	logic        pad_q, first_q, need_extra_q, last_q, out_valid_q;
	chain_t      h_q, dig_q, work;
	core_ctl_t   ctl;
	logic        accept, len_sel, out_free;
	logic [7:0]  pad_byte;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign len_sel = !first_q && (fill_q >= LEN_POS) && !need_extra_q;
	assign pad_byte = first_q ? PAD_MARK : (len_sel ? bits_q[63:56] : 8'h00);

	always_comb begin
		ctl.push = (accept && kind == KIND_DATA) || (state_q == S_PAD);
		ctl.byte_val = (state_q == S_PAD) ? pad_byte : data_byte;
		ctl.load = ctl.push && (fill_q == LAST_POS);
		ctl.step = (state_q == S_ROUND);
		ctl.round = round_q;
	end

	sha1bs_core u_core (
		.clk   (clk),
		.ctl   (ctl),
		.chain (h_q),
		.work  (work)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			round_q <= '0;
			pad_q <= 1'b0;
			first_q <= 1'b0;
			need_extra_q <= 1'b0;
			last_q <= 1'b0;
			h_q <= CHAIN_IV;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_DATA) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
							if (fill_q == LAST_POS) begin
								round_q <= '0;
								state_q <= S_ROUND;
							end
						end else begin
							pad_q <= 1'b1;
							first_q <= 1'b1;
							need_extra_q <= (fill_q >= LEN_POS);
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					fill_q <= fill_q + 6'd1;
					if (len_sel) begin
						bits_q <= {bits_q[55:0], 8'h00};
					end
					if (fill_q == LAST_POS) begin
						last_q <= !need_extra_q;
						round_q <= '0;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == LAST_ROUND) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					for (int i = 0; i < 5; i++) begin
						h_q[i] <= h_q[i] + work[i];
					end
					need_extra_q <= 1'b0;
					if (last_q) begin
						state_q <= S_OUT;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_free) begin
						h_q <= CHAIN_IV;
						fill_q <= '0;
						bits_q <= '0;
						pad_q <= 1'b0;
						last_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			dig_q <= h_q;
		end
	end

	assign out_valid = out_valid_q;
	assign digest_h0 = dig_q[0];
	assign digest_h1 = dig_q[1];
	assign digest_h2 = dig_q[2];
	assign digest_h3 = dig_q[3];
	assign digest_h4 = dig_q[4];

`ifndef SYNTHESIS
	a_round_to_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && round_q == LAST_ROUND) |=> (state_q == S_FINAL))
		else $error("round sequence did not end in the chain update");
	a_final_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINAL) |-> (fill_q == 6'd0))
		else $error("chain update with a partly filled block");
	a_out_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (last_q && pad_q))
		else $error("digest stage reached without a final padded block");
	a_extra_in_pad: assert property (@(posedge clk) disable iff (!arst_n)
		need_extra_q |-> pad_q)
		else $error("extra padding block flagged outside a finish");
`endif

endmodule
`default_nettype wire
